>>> hdl/tun_pkg.sv
// Shared types and widths for the triangle unit normal core.
// No dependencies; every other file imports this package.
package tun_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int IN_W  = 16;
    localparam int E_W   = 17;
    localparam int P_W   = 34;
    localparam int C_W   = 35;
    localparam int M_W   = 34;
    localparam int H_W   = 17;
    localparam int SQ_W  = 68;
    localparam int L_W   = 70;
    localparam int ACC_W = 100;
    localparam int Q_BITS = 15;
    localparam int OUT_W = 16;

    typedef struct packed {
        logic signed [C_W-1:0] x;
        logic signed [C_W-1:0] y;
        logic signed [C_W-1:0] z;
    } t_cross;

endpackage

>>> hdl/tun_front.sv
// Front part: edge vectors and cross product, three pipeline stages.
// Depends on tun_pkg.
module tun_front
    import tun_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [IN_W-1:0] i_p1_x,
    input  logic signed [IN_W-1:0] i_p1_y,
    input  logic signed [IN_W-1:0] i_p1_z,
    input  logic signed [IN_W-1:0] i_p2_x,
    input  logic signed [IN_W-1:0] i_p2_y,
    input  logic signed [IN_W-1:0] i_p2_z,
    input  logic signed [IN_W-1:0] i_p3_x,
    input  logic signed [IN_W-1:0] i_p3_y,
    input  logic signed [IN_W-1:0] i_p3_z,
    output logic                   o_valid,
    input  logic                   i_ready,
    output t_cross                 o_cross
);

    logic r_v1, r_v2, r_v3;
    logic en;
    logic signed [E_W-1:0] r_ax, r_ay, r_az, r_bx, r_by, r_bz;
    logic signed [P_W-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    t_cross r_cross;

    assign en      = !r_v3 || i_ready;
    assign o_ready = en;
    assign o_valid = r_v3;
    assign o_cross = r_cross;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax <= {i_p1_x[IN_W-1], i_p1_x} - {i_p2_x[IN_W-1], i_p2_x};
            r_ay <= {i_p1_y[IN_W-1], i_p1_y} - {i_p2_y[IN_W-1], i_p2_y};
            r_az <= {i_p1_z[IN_W-1], i_p1_z} - {i_p2_z[IN_W-1], i_p2_z};
            r_bx <= {i_p1_x[IN_W-1], i_p1_x} - {i_p3_x[IN_W-1], i_p3_x};
            r_by <= {i_p1_y[IN_W-1], i_p1_y} - {i_p3_y[IN_W-1], i_p3_y};
            r_bz <= {i_p1_z[IN_W-1], i_p1_z} - {i_p3_z[IN_W-1], i_p3_z};
            r_p0 <= r_ay * r_bz;
            r_p1 <= r_by * r_az;
            r_p2 <= r_bx * r_az;
            r_p3 <= r_ax * r_bz;
            r_p4 <= r_ax * r_by;
            r_p5 <= r_bx * r_ay;
            r_cross.x <= {r_p0[P_W-1], r_p0} - {r_p1[P_W-1], r_p1};
            r_cross.y <= {r_p2[P_W-1], r_p2} - {r_p3[P_W-1], r_p3};
            r_cross.z <= {r_p4[P_W-1], r_p4} - {r_p5[P_W-1], r_p5};
        end
    end

endmodule

>>> hdl/tun_fifo.sv
// Short queue of cross products between the front and back parts.
// Depends on tun_pkg.
module tun_fifo
    import tun_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr_valid,
    output logic   o_wr_ready,
    input  t_cross i_wr_data,
    output logic   o_rd_valid,
    input  logic   i_rd_ready,
    output t_cross o_rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cross r_mem [0:DEPTH-1];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic wr, rd;

    assign o_wr_ready = (r_cnt != CW'(DEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign o_rd_data  = r_mem[r_rp];
    assign wr = i_wr_valid && o_wr_ready;
    assign rd = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (rd) r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            if (wr && !rd) r_cnt <= r_cnt + 1'b1;
            else if (rd && !wr) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_wr_data;
    end

endmodule

>>> hdl/tun_back.sv
// Back part: squared length, then one quotient bit per digit stage for each lane.
// Depends on tun_pkg.
module tun_back
    import tun_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  t_cross                  i_cross,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [OUT_W-1:0] o_normal_x,
    output logic signed [OUT_W-1:0] o_normal_y,
    output logic signed [OUT_W-1:0] o_normal_z,
    output logic                    o_degenerate
);

    logic en;
    logic r_v0, r_v1, r_v2, r_vo;
    logic [Q_BITS:0] r_vd;

    logic signed [C_W-1:0] c_in [0:2];
    logic [M_W-1:0] r0_m [0:2];
    logic           r0_s [0:2];
    logic [2*H_W-1:0] r1_hh [0:2];
    logic [2*H_W-1:0] r1_hl [0:2];
    logic [2*H_W-1:0] r1_ll [0:2];
    logic           r1_s [0:2];
    logic [SQ_W-1:0] r2_sq [0:2];
    logic           r2_s [0:2];

    logic [ACC_W-1:0]  r_ds [0:Q_BITS][0:2];
    logic [ACC_W-1:0]  r_dt [0:Q_BITS][0:2];
    logic [Q_BITS-1:0] r_dq [0:Q_BITS][0:2];
    logic [ACC_W-1:0]  r_dr [0:Q_BITS][0:2];
    logic              r_dsg [0:Q_BITS][0:2];
    logic [ACC_W-1:0]  r_dl [0:Q_BITS];
    logic              r_ddeg [0:Q_BITS];

    logic signed [OUT_W-1:0] r_nx, r_ny, r_nz;
    logic r_deg;

    assign en      = !r_vo || i_ready;
    assign o_ready = en;
    assign o_valid = r_vo;
    assign o_normal_x   = r_nx;
    assign o_normal_y   = r_ny;
    assign o_normal_z   = r_nz;
    assign o_degenerate = r_deg;

    assign c_in[0] = i_cross.x;
    assign c_in[1] = i_cross.y;
    assign c_in[2] = i_cross.z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vd <= '0;
            r_vo <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_vd <= {r_vd[Q_BITS-1:0], r_v2};
            r_vo <= r_vd[Q_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [C_W-1:0] neg;
        logic [SQ_W-1:0] sum;
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                neg = -c_in[i];
                r0_s[i] <= c_in[i][C_W-1];
                r0_m[i] <= c_in[i][C_W-1] ? neg[M_W-1:0] : c_in[i][M_W-1:0];
                r1_hh[i] <= r0_m[i][M_W-1:H_W] * r0_m[i][M_W-1:H_W];
                r1_hl[i] <= r0_m[i][M_W-1:H_W] * r0_m[i][H_W-1:0];
                r1_ll[i] <= r0_m[i][H_W-1:0] * r0_m[i][H_W-1:0];
                r1_s[i]  <= r0_s[i];
                sum = {r1_hh[i], {(2*H_W){1'b0}}}
                    + {{(SQ_W-2*H_W-H_W-1){1'b0}}, r1_hl[i], {(H_W+1){1'b0}}}
                    + {{(SQ_W-2*H_W){1'b0}}, r1_ll[i]};
                r2_sq[i] <= sum;
                r2_s[i]  <= r1_s[i];
                r_ds[0][i]  <= '0;
                r_dt[0][i]  <= '0;
                r_dq[0][i]  <= '0;
                r_dr[0][i]  <= {{(ACC_W-SQ_W-28){1'b0}}, r2_sq[i], 28'b0};
                r_dsg[0][i] <= r2_s[i];
            end
            r_dl[0] <= ACC_W'(r2_sq[0]) + ACC_W'(r2_sq[1]) + ACC_W'(r2_sq[2]);
            r_ddeg[0] <= (r2_sq[0] == '0) && (r2_sq[1] == '0) && (r2_sq[2] == '0);
        end
    end

    for (genvar j = 0; j < Q_BITS; j++) begin : g_digit
        localparam int K = Q_BITS - 1 - j;
        always_ff @(posedge i_clk) begin
            logic [ACC_W-1:0] cand;
            logic acc;
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    cand = r_ds[j][i] + (r_dt[j][i] << (K + 1)) + (r_dl[j] << (2 * K));
                    acc  = (cand <= r_dr[j][i]);
                    r_ds[j+1][i] <= acc ? cand : r_ds[j][i];
                    r_dt[j+1][i] <= acc ? r_dt[j][i] + (r_dl[j] << K) : r_dt[j][i];
                    r_dq[j+1][i] <= r_dq[j][i] | (Q_BITS'(acc) << K);
                    r_dr[j+1][i] <= r_dr[j][i];
                    r_dsg[j+1][i] <= r_dsg[j][i];
                end
                r_dl[j+1]   <= r_dl[j];
                r_ddeg[j+1] <= r_ddeg[j];
            end
        end
    end

    function automatic logic signed [OUT_W-1:0] f_apply(
        input logic [Q_BITS-1:0] q, input logic s, input logic deg);
        logic [OUT_W-1:0] v;
        v = {{(OUT_W-Q_BITS){1'b0}}, q};
        if (deg) return '0;
        return s ? -v : v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nx  <= f_apply(r_dq[Q_BITS][0], r_dsg[Q_BITS][0], r_ddeg[Q_BITS]);
            r_ny  <= f_apply(r_dq[Q_BITS][1], r_dsg[Q_BITS][1], r_ddeg[Q_BITS]);
            r_nz  <= f_apply(r_dq[Q_BITS][2], r_dsg[Q_BITS][2], r_ddeg[Q_BITS]);
            r_deg <= r_ddeg[Q_BITS];
        end
    end

endmodule

>>> hdl/triangle_unit_normal_core.sv
// Triangle unit normal core: front (cross product), queue, back (normalize).
// Path: 3 front stages, the queue, 20 back stages. Throughput one triangle per cycle
// while i_ready holds; each back digit stage resolves one quotient bit per lane.
// Reset clears valid flags, queue pointers and count only; the datapath needs no reset.
// Depends on tun_pkg, tun_front, tun_fifo, tun_back.
module triangle_unit_normal_core
    import tun_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [IN_W-1:0]  i_p1_x,
    input  logic signed [IN_W-1:0]  i_p1_y,
    input  logic signed [IN_W-1:0]  i_p1_z,
    input  logic signed [IN_W-1:0]  i_p2_x,
    input  logic signed [IN_W-1:0]  i_p2_y,
    input  logic signed [IN_W-1:0]  i_p2_z,
    input  logic signed [IN_W-1:0]  i_p3_x,
    input  logic signed [IN_W-1:0]  i_p3_y,
    input  logic signed [IN_W-1:0]  i_p3_z,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [OUT_W-1:0] o_normal_x,
    output logic signed [OUT_W-1:0] o_normal_y,
    output logic signed [OUT_W-1:0] o_normal_z,
    output logic                    o_degenerate
);

    logic   f_valid, f_ready, b_valid, b_ready;
    t_cross f_cross, b_cross;

    tun_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_p1_x, .i_p1_y, .i_p1_z, .i_p2_x, .i_p2_y, .i_p2_z,
        .i_p3_x, .i_p3_y, .i_p3_z,
        .o_valid(f_valid), .i_ready(f_ready), .o_cross(f_cross)
    );

    tun_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk, .i_rst_n,
        .i_wr_valid(f_valid), .o_wr_ready(f_ready), .i_wr_data(f_cross),
        .o_rd_valid(b_valid), .i_rd_ready(b_ready), .o_rd_data(b_cross)
    );

    tun_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(b_valid), .o_ready(b_ready), .i_cross(b_cross),
        .o_valid, .i_ready,
        .o_normal_x, .o_normal_y, .o_normal_z, .o_degenerate
    );

endmodule
